FILE: rtl/core/fspa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// fspa_pkg: shared widths, reset values, command and status codes of the pool allocator
// used by the channel interfaces and the allocator top level, depends on nothing

package fspa_pkg;

    // default pool depth
    localparam int SLOTS_DEF      = 64;

    // stride rules
    localparam int MIN_SLOT_BYTES = 8;
    localparam int MIN_ALIGN_LOG2 = 3;
    localparam int MAX_ALIGN_LOG2 = 12;

    // field widths
    localparam int CMD_W    = 2;
    localparam int OFF_W    = 18;
    localparam int STATUS_W = 3;
    localparam int SIZE_W   = 13;
    localparam int ALIGN_W  = 4;
    localparam int COUNT_W  = 7;
    localparam int STRIDE_W = 14;

    // register port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_SLOT_SIZE  = 2'd0;
    localparam logic [1:0] REG_ALIGN_LOG2 = 2'd1;
    localparam logic [1:0] REG_SLOT_COUNT = 2'd2;

    // register reset values
    localparam logic [SIZE_W-1:0]  SLOT_SIZE_RST  = 13'd16;
    localparam logic [ALIGN_W-1:0] ALIGN_LOG2_RST = 4'd4;
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_LIST  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_OUT_OF_RANGE = 3'd2,
        ST_MISALIGNED   = 3'd3,
        ST_NOT_ALLOC    = 3'd4,
        ST_NONE_ALIVE   = 3'd5
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/core/fspa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// fspa_cmd_if / fspa_res_if: valid-ready channels for command items and result items
// depends on fspa_pkg for field widths

interface fspa_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [fspa_pkg::CMD_W-1:0]   command;
    logic [fspa_pkg::OFF_W-1:0]   byte_offset;

    modport source (output valid, output command, output byte_offset, input ready);
    modport sink   (input valid, input command, input byte_offset, output ready);
endinterface

interface fspa_res_if #(
    parameter int IDX_W  = 6,
    parameter int LIVE_W = 7
);
    logic                          valid;
    logic                          ready;
    logic [fspa_pkg::STATUS_W-1:0] status;
    logic [fspa_pkg::OFF_W-1:0]    slot_offset;
    logic [IDX_W-1:0]              slot_index;
    logic [LIVE_W-1:0]             live_slots;
    logic                          last;

    modport source (output valid, output status, output slot_offset, output slot_index,
                    output live_slots, output last, input ready);
    modport sink   (input valid, input status, input slot_offset, input slot_index,
                    input live_slots, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fixed_slot_pool_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// fixed_slot_pool_allocator_unit: pool of equal slots with a lifo free stack and alive flags
// depends on fspa_pkg, fspa_if (command and result channels) and fspa_ram

// The pool holds SLOTS equal slots. The stride is slot_size raised to 8 bytes and rounded up
// to 2**alignment_log2 (alignment taken between 3 and 12). Free slot indices sit on a lifo
// stack in one ram, the alive flags in a second ram. slot_count is applied only by reset or
// by the reset-pool command. One item is worked at a time; the result register lets the next
// item in while a result waits. Allocate reads the stack top, then writes the flag; free runs
// a limit multiply, a range check, the divider at one quotient bit per cycle, a flag read and
// the write back; list reads one flag per slot in use through the single ram port; reset pool
// runs a clearing pass and then replies. After reset, and after each reset-pool command, the
// clearing pass rewrites both rams, one entry per cycle; no item is taken meanwhile while
// register writes are taken as ever.
module fixed_slot_pool_allocator_unit #(
    parameter int SLOTS = fspa_pkg::SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    fspa_cmd_if.sink                          i_cmd_if,
    fspa_res_if.source                        o_res_if,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fspa_pkg::PADDR_W-1:0] paddr,
    input  wire logic [fspa_pkg::PDATA_W-1:0] pwdata,
    output logic      [fspa_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);

    localparam int IW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int SW   = $clog2(IW + 1);
    localparam int LW   = fspa_pkg::STRIDE_W + CW;
    localparam int DW   = fspa_pkg::STRIDE_W + IW;
    localparam int OW   = fspa_pkg::OFF_W;
    localparam int CMPW = (LW > OW) ? ((LW > DW) ? LW : DW) : ((OW > DW) ? OW : DW);
    localparam int ACTIVE_RST = (64 > SLOTS) ? SLOTS : 64;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_RST_OUT,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_FREE_LIM,
        S_FREE_RNG,
        S_DIV,
        S_FREE_CHK,
        S_FREE_WR,
        S_LIST_RD,
        S_LIST_CHK,
        S_LIST_END
    } t_state;

    // ---------------------------------------------------------------- config registers
    logic [fspa_pkg::SIZE_W-1:0]  r_slot_size;
    logic [fspa_pkg::ALIGN_W-1:0] r_align_log2;
    logic [fspa_pkg::COUNT_W-1:0] r_slot_count;
    logic                         w_pwr;

    assign pready = 1'b1;
    assign w_pwr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_size  <= fspa_pkg::SLOT_SIZE_RST;
            r_align_log2 <= fspa_pkg::ALIGN_LOG2_RST;
            r_slot_count <= fspa_pkg::SLOT_COUNT_RST;
        end else if (w_pwr) begin
            unique case (paddr[3:2])
                fspa_pkg::REG_SLOT_SIZE:  r_slot_size  <= pwdata[fspa_pkg::SIZE_W-1:0];
                fspa_pkg::REG_ALIGN_LOG2: r_align_log2 <= pwdata[fspa_pkg::ALIGN_W-1:0];
                fspa_pkg::REG_SLOT_COUNT: r_slot_count <= pwdata[fspa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            fspa_pkg::REG_SLOT_SIZE:
                prdata = fspa_pkg::PDATA_W'(r_slot_size);
            fspa_pkg::REG_ALIGN_LOG2:
                prdata = fspa_pkg::PDATA_W'(r_align_log2);
            fspa_pkg::REG_SLOT_COUNT:
                prdata = fspa_pkg::PDATA_W'(r_slot_count);
            default:
                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- stride
    logic [fspa_pkg::SIZE_W-1:0]   w_size_cl;
    logic [fspa_pkg::ALIGN_W-1:0]  w_align_cl;
    logic [fspa_pkg::SIZE_W-1:0]   w_mask;
    logic [fspa_pkg::STRIDE_W-1:0] w_stride;
    logic [fspa_pkg::STRIDE_W-1:0] r_stride;
    logic [CW-1:0]                 w_count_sat;

    always_comb begin
        if (r_slot_size < fspa_pkg::SIZE_W'(fspa_pkg::MIN_SLOT_BYTES)) begin
            w_size_cl = fspa_pkg::SIZE_W'(fspa_pkg::MIN_SLOT_BYTES);
        end else begin
            w_size_cl = r_slot_size;
        end
        if (r_align_log2 < fspa_pkg::ALIGN_W'(fspa_pkg::MIN_ALIGN_LOG2)) begin
            w_align_cl = fspa_pkg::ALIGN_W'(fspa_pkg::MIN_ALIGN_LOG2);
        end else if (r_align_log2 > fspa_pkg::ALIGN_W'(fspa_pkg::MAX_ALIGN_LOG2)) begin
            w_align_cl = fspa_pkg::ALIGN_W'(fspa_pkg::MAX_ALIGN_LOG2);
        end else begin
            w_align_cl = r_align_log2;
        end
        w_mask   = (fspa_pkg::SIZE_W'(1) << w_align_cl) - fspa_pkg::SIZE_W'(1);
        w_stride = ({1'b0, w_size_cl} + {1'b0, w_mask}) & ~{1'b0, w_mask};
        if (32'(r_slot_count) > 32'(SLOTS)) begin
            w_count_sat = CW'(SLOTS);
        end else begin
            w_count_sat = CW'(r_slot_count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_stride <= w_stride;
    end

    // ---------------------------------------------------------------- rams
    logic            stack_we;
    logic [IW-1:0]   stack_addr;
    logic [IW-1:0]   stack_wdata;
    logic [IW-1:0]   stack_rdata;
    logic            alive_we;
    logic [IW-1:0]   alive_addr;
    logic            alive_wdata;
    logic            alive_rdata;

    fspa_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_addr  (stack_addr),
        .i_wdata (stack_wdata),
        .o_rdata (stack_rdata)
    );

    fspa_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_alive_ram (
        .i_clk   (i_clk),
        .i_we    (alive_we),
        .i_addr  (alive_addr),
        .i_wdata (alive_wdata),
        .o_rdata (alive_rdata)
    );

    // ---------------------------------------------------------------- control
    t_state                    r_state, n_state;
    logic [fspa_pkg::OFF_W-1:0] r_off, n_off;
    logic [CW-1:0]             r_active, n_active;
    logic [CW-1:0]             r_depth, n_depth;
    logic [CW-1:0]             r_live, n_live;
    logic [CW-1:0]             r_scan, n_scan;
    logic                      r_sweep_reply, n_sweep_reply;
    logic [LW-1:0]             r_limit, n_limit;
    logic [OW-1:0]             r_rem, n_rem;
    logic [DW-1:0]             r_dvs, n_dvs;
    logic [IW-1:0]             r_quo, n_quo;
    logic [SW-1:0]             r_step, n_step;
    logic                      r_pend_valid, n_pend_valid;
    logic [IW-1:0]             r_pend_idx, n_pend_idx;

    logic                      r_ovalid, n_ovalid;
    fspa_pkg::t_status         r_o_status, n_o_status;
    logic [OW-1:0]             r_o_off, n_o_off;
    logic [IW-1:0]             r_o_idx, n_o_idx;
    logic [CW-1:0]             r_o_live, n_o_live;
    logic                      r_o_last, n_o_last;

    logic                      w_can_emit;
    logic                      w_emit;
    fspa_pkg::t_status         w_e_status;
    logic [OW-1:0]             w_e_off;
    logic [IW-1:0]             w_e_idx;
    logic [CW-1:0]             w_e_live;
    logic                      w_e_last;
    logic [IW-1:0]             w_mul_idx;
    logic [OW-1:0]             w_mul_off;
    logic [CW-1:0]             w_depth_m1;
    logic                      w_ge;

    assign w_can_emit = !r_ovalid || o_res_if.ready;
    assign w_depth_m1 = r_depth - CW'(1);
    assign w_mul_off  = OW'(w_mul_idx) * OW'(r_stride);
    assign w_ge       = CMPW'(r_rem) >= CMPW'(r_dvs);

    always_comb begin
        n_state       = r_state;
        n_off         = r_off;
        n_active      = r_active;
        n_depth       = r_depth;
        n_live        = r_live;
        n_scan        = r_scan;
        n_sweep_reply = r_sweep_reply;
        n_limit       = r_limit;
        n_rem         = r_rem;
        n_dvs         = r_dvs;
        n_quo         = r_quo;
        n_step        = r_step;
        n_pend_valid  = r_pend_valid;
        n_pend_idx    = r_pend_idx;

        stack_we    = 1'b0;
        stack_addr  = w_depth_m1[IW-1:0];
        stack_wdata = r_quo;
        alive_we    = 1'b0;
        alive_addr  = r_quo;
        alive_wdata = 1'b0;

        w_emit     = 1'b0;
        w_e_status = fspa_pkg::ST_OK;
        w_e_off    = '0;
        w_e_idx    = '0;
        w_e_live   = r_live;
        w_e_last   = 1'b1;
        w_mul_idx  = stack_rdata;

        unique case (r_state)
            S_SWEEP: begin
                stack_we    = 1'b1;
                stack_addr  = r_scan[IW-1:0];
                stack_wdata = r_scan[IW-1:0];
                alive_we    = 1'b1;
                alive_addr  = r_scan[IW-1:0];
                alive_wdata = 1'b0;
                n_scan      = r_scan + CW'(1);
                if (r_scan == CW'(SLOTS - 1)) begin
                    n_state = r_sweep_reply ? S_RST_OUT : S_IDLE;
                end
            end
            S_RST_OUT: begin
                if (w_can_emit) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_if.valid) begin
                    n_off = i_cmd_if.byte_offset;
                    unique case (fspa_pkg::t_cmd'(i_cmd_if.command))
                        fspa_pkg::CMD_ALLOC: n_state = S_ALLOC_RD;
                        fspa_pkg::CMD_FREE:  n_state = S_FREE_LIM;
                        fspa_pkg::CMD_RESET: begin
                            n_active      = w_count_sat;
                            n_depth       = w_count_sat;
                            n_live        = '0;
                            n_scan        = '0;
                            n_sweep_reply = 1'b1;
                            n_state       = S_SWEEP;
                        end
                        fspa_pkg::CMD_LIST: begin
                            n_scan       = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_LIST_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_ALLOC_RD: begin
                if (r_depth == '0) begin
                    if (w_can_emit) begin
                        w_emit     = 1'b1;
                        w_e_status = fspa_pkg::ST_EMPTY;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_state = S_ALLOC_WR;
                end
            end
            S_ALLOC_WR: begin
                // stack address still points at the top entry
                alive_addr  = stack_rdata;
                if (w_can_emit) begin
                    alive_we    = 1'b1;
                    alive_wdata = 1'b1;
                    n_depth     = w_depth_m1;
                    n_live      = r_live + CW'(1);
                    w_emit      = 1'b1;
                    w_e_off     = w_mul_off;
                    w_e_idx     = stack_rdata;
                    w_e_live    = r_live + CW'(1);
                    n_state     = S_IDLE;
                end
            end
            S_FREE_LIM: begin
                n_limit = LW'(r_stride) * LW'(r_active);
                n_state = S_FREE_RNG;
            end
            S_FREE_RNG: begin
                if (CMPW'(r_off) >= CMPW'(r_limit)) begin
                    if (w_can_emit) begin
                        w_emit     = 1'b1;
                        w_e_status = fspa_pkg::ST_OUT_OF_RANGE;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_rem   = r_off;
                    n_dvs   = DW'(r_stride) << (IW - 1);
                    n_quo   = '0;
                    n_step  = SW'(IW - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle, msb first
                if (w_ge) begin
                    n_rem = r_rem - OW'(r_dvs);
                end
                n_quo = (r_quo << 1) | IW'(w_ge);
                n_dvs = r_dvs >> 1;
                n_step = r_step - SW'(1);
                if (r_step == '0) begin
                    n_state = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (r_rem != '0) begin
                    if (w_can_emit) begin
                        w_emit     = 1'b1;
                        w_e_status = fspa_pkg::ST_MISALIGNED;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_state = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                stack_addr = r_depth[IW-1:0];
                if (!alive_rdata || r_live == '0 || r_depth >= CW'(SLOTS)) begin
                    if (w_can_emit) begin
                        w_emit     = 1'b1;
                        w_e_status = fspa_pkg::ST_NOT_ALLOC;
                        n_state    = S_IDLE;
                    end
                end else if (w_can_emit) begin
                    alive_we    = 1'b1;
                    alive_wdata = 1'b0;
                    stack_we    = 1'b1;
                    n_depth     = r_depth + CW'(1);
                    n_live      = r_live - CW'(1);
                    w_emit      = 1'b1;
                    w_e_off     = r_off;
                    w_e_idx     = r_quo;
                    w_e_live    = r_live - CW'(1);
                    n_state     = S_IDLE;
                end
            end
            S_LIST_RD: begin
                alive_addr = r_scan[IW-1:0];
                if (r_scan >= r_active) begin
                    n_state = S_LIST_END;
                end else begin
                    n_state = S_LIST_CHK;
                end
            end
            S_LIST_CHK: begin
                // one alive slot is held back so that the final one can carry last
                alive_addr = r_scan[IW-1:0];
                w_mul_idx  = r_pend_idx;
                if (!alive_rdata) begin
                    n_scan  = r_scan + CW'(1);
                    n_state = S_LIST_RD;
                end else if (!r_pend_valid) begin
                    n_pend_valid = 1'b1;
                    n_pend_idx   = r_scan[IW-1:0];
                    n_scan       = r_scan + CW'(1);
                    n_state      = S_LIST_RD;
                end else if (w_can_emit) begin
                    w_emit     = 1'b1;
                    w_e_off    = w_mul_off;
                    w_e_idx    = r_pend_idx;
                    w_e_last   = 1'b0;
                    n_pend_idx = r_scan[IW-1:0];
                    n_scan     = r_scan + CW'(1);
                    n_state    = S_LIST_RD;
                end
            end
            S_LIST_END: begin
                w_mul_idx = r_pend_idx;
                if (w_can_emit) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    if (r_pend_valid) begin
                        w_e_off = w_mul_off;
                        w_e_idx = r_pend_idx;
                    end else begin
                        w_e_status = fspa_pkg::ST_NONE_ALIVE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_ovalid   = r_ovalid;
        n_o_status = r_o_status;
        n_o_off    = r_o_off;
        n_o_idx    = r_o_idx;
        n_o_live   = r_o_live;
        n_o_last   = r_o_last;
        if (w_emit) begin
            n_ovalid   = 1'b1;
            n_o_status = w_e_status;
            n_o_off    = w_e_off;
            n_o_idx    = w_e_idx;
            n_o_live   = w_e_live;
            n_o_last   = w_e_last;
        end else if (o_res_if.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_active      <= CW'(ACTIVE_RST);
            r_depth       <= CW'(ACTIVE_RST);
            r_live        <= '0;
            r_scan        <= '0;
            r_sweep_reply <= 1'b0;
            r_step        <= '0;
            r_pend_valid  <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_active      <= n_active;
            r_depth       <= n_depth;
            r_live        <= n_live;
            r_scan        <= n_scan;
            r_sweep_reply <= n_sweep_reply;
            r_step        <= n_step;
            r_pend_valid  <= n_pend_valid;
            r_ovalid      <= n_ovalid;
        end
        r_off      <= n_off;
        r_limit    <= n_limit;
        r_rem      <= n_rem;
        r_dvs      <= n_dvs;
        r_quo      <= n_quo;
        r_pend_idx <= n_pend_idx;
        r_o_status <= n_o_status;
        r_o_off    <= n_o_off;
        r_o_idx    <= n_o_idx;
        r_o_live   <= n_o_live;
        r_o_last   <= n_o_last;
    end

    assign i_cmd_if.ready       = (r_state == S_IDLE);
    assign o_res_if.valid       = r_ovalid;
    assign o_res_if.status      = r_o_status;
    assign o_res_if.slot_offset = r_o_off;
    assign o_res_if.slot_index  = r_o_idx;
    assign o_res_if.live_slots  = r_o_live;
    assign o_res_if.last        = r_o_last;

`ifndef SYNTHESIS
    // every slot in use is either alive or on the free stack
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_live) + 32'(r_depth)) == 32'(r_active))
        else $error("live count and free depth do not add up to the pool size");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_active)
        else $error("live count above pool size");

    // a range-checked, aligned offset must divide to an index inside the pool
    a_div_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE_CHK && r_rem == '0) |-> (CW'(r_quo) < r_active))
        else $error("divider quotient outside the pool");

    a_ok_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_if.valid && o_res_if.status == fspa_pkg::ST_OK && o_res_if.live_slots != '0)
        |-> (CW'(o_res_if.slot_index) < r_active))
        else $error("reported slot index outside the pool");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/fspa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// fspa_ram: single-port synchronous ram, one write or read per cycle, registered read data
// no dependencies

module fspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
